// File: src/sve_pkg.sv
`default_nettype none
package sve_pkg;
  localparam int MEM_AW = 12;
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW = 4;
  localparam int SCREEN_ROWS = 32;
  localparam int ROW_AW = 5;
  localparam int SCREEN_COLUMNS = 64;

  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] PC_RESET = 12'd512;

  localparam logic [5:0] OP_CLEAR = 6'd0;
  localparam logic [5:0] OP_DRAW = 6'd1;
  localparam logic [5:0] OP_JUMP = 6'd2;
  localparam logic [5:0] OP_JUMPOFF = 6'd3;
  localparam logic [5:0] OP_CALL = 6'd4;
  localparam logic [5:0] OP_RET = 6'd5;
  localparam logic [5:0] OP_SEQ_N = 6'd6;
  localparam logic [5:0] OP_SNE_N = 6'd7;
  localparam logic [5:0] OP_SEQ_R = 6'd8;
  localparam logic [5:0] OP_SNE_R = 6'd9;
  localparam logic [5:0] OP_LD_N = 6'd10;
  localparam logic [5:0] OP_ADD_N = 6'd11;
  localparam logic [5:0] OP_MOV = 6'd12;
  localparam logic [5:0] OP_OR = 6'd13;
  localparam logic [5:0] OP_AND = 6'd14;
  localparam logic [5:0] OP_XOR = 6'd15;
  localparam logic [5:0] OP_SHR = 6'd16;
  localparam logic [5:0] OP_SHL = 6'd17;
  localparam logic [5:0] OP_ADC = 6'd18;
  localparam logic [5:0] OP_SUB = 6'd19;
  localparam logic [5:0] OP_SUBN = 6'd20;
  localparam logic [5:0] OP_LDI = 6'd21;
  localparam logic [5:0] OP_ADDI = 6'd22;
  localparam logic [5:0] OP_FONT = 6'd23;
  localparam logic [5:0] OP_STORE = 6'd24;
  localparam logic [5:0] OP_LOAD = 6'd25;
  localparam logic [5:0] OP_RAND = 6'd26;
  localparam logic [5:0] OP_SET_DT = 6'd27;
  localparam logic [5:0] OP_GET_DT = 6'd28;
  localparam logic [5:0] OP_SET_ST = 6'd29;
  localparam logic [5:0] OP_BCD = 6'd30;
  localparam logic [5:0] OP_HOSTWR = 6'd31;
  localparam logic [5:0] OP_ROWRD = 6'd32;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  localparam logic [1:0] CFG_SHIFT = 2'd0;
  localparam logic [1:0] CFG_JUMP = 2'd1;
  localparam logic [1:0] CFG_ADV = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [11:0] next_pc;
    logic [15:0] index_value;
    logic [7:0] flag_value;
    logic [63:0] display_row;
  } result_t;
endpackage
`default_nettype wire

// File: src/sprite_vm_execute_unit_core.sv
// channel | signals                                              | beat when
// in      | in_valid in_ready operation reg_x reg_y immediate     | in_valid & in_ready
//         | random_byte host_data                                |
// out     | out_valid out_ready status next_pc index_value        | out_valid & out_ready
//         | flag_value display_row                               |
// cfg     | cfg_we cfg_index cfg_data                            | cfg_we
// One item at a time; in_ready is low from accept until its result is taken.
// Draw updates one frame row per sprite byte read; store and load move
// one memory byte per step over the shared memory port; BCD subtracts
// hundreds, then tens, and writes 3 digits; clear drops frame valid bits.
// Reset (rst, synchronous) clears registers, frame valid bits, stack count.
// A held result stalls nothing else but the next input accept.
`default_nettype none
module sprite_vm_execute_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  operation,
  input  wire logic [3:0]  reg_x,
  input  wire logic [3:0]  reg_y,
  input  wire logic [11:0] immediate,
  input  wire logic [7:0]  random_byte,
  input  wire logic [7:0]  host_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [11:0]      next_pc,
  output logic [15:0]      index_value,
  output logic [7:0]       flag_value,
  output logic [63:0]      display_row,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);
  import sve_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MRD = 3'd2;
  localparam logic [2:0] S_MUSE = 3'd3;
  localparam logic [2:0] S_MWR = 3'd4;
  localparam logic [2:0] S_CLR = 3'd5;
  localparam logic [2:0] S_BCD = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  logic shift_uses_vy, jump_offset_uses_vx, store_load_advances_index;

  logic [7:0] mem [0:(1<<MEM_AW)-1];
  logic [63:0] frame [0:SCREEN_ROWS-1];
  logic [SCREEN_ROWS-1:0] frame_ok;
  logic [7:0] v [0:15];
  logic [15:0] index_reg;
  logic [11:0] pc_reg;
  logic [11:0] stack [0:STACK_DEPTH-1];
  logic [STK_AW:0] stack_count;
  logic [7:0] delay_count, sound_count;

  logic [5:0] op;
  logic [3:0] rx, ry;
  logic [11:0] imm;
  logic [7:0] rnd, hdat;
  logic [4:0] step;
  logic [7:0] mem_rd;
  logic [MEM_AW-1:0] mem_a;
  logic [7:0] bcd_val, bcd_h, bcd_t;
  logic [1:0] st;
  logic [63:0] row_r;
  logic [5:0] col;
  logic [ROW_AW-1:0] top;
  result_t res;

  wire [7:0] vx = v[rx];
  wire [7:0] vy = v[ry];
  wire [ROW_AW:0] drow = {1'b0, top} + {2'b0, step[3:0]};
  wire [63:0] cur_row = frame_ok[drow[ROW_AW-1:0]] ? frame[drow[ROW_AW-1:0]] : 64'd0;
  wire [127:0] wide = {mem_rd, 120'd0} >> col;
  wire [63:0] bits = wide[127:64];
  wire [ROW_AW-1:0] rd_sel = imm[ROW_AW-1:0];
  wire [15:0] addr16 = index_reg + {11'd0, step};
  wire [8:0] sum9 = {1'b0, vx} + {1'b0, vy};
  wire [8:0] jsrc = jump_offset_uses_vx ? {1'b0, v[imm[11:8]]} : {1'b0, v[0]};
  wire [7:0] sh_src = shift_uses_vy ? vy : vx;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_uses_vy <= 1'b1;
      jump_offset_uses_vx <= 1'b0;
      store_load_advances_index <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHIFT: shift_uses_vy <= cfg_data;
        CFG_JUMP: jump_offset_uses_vx <= cfg_data;
        CFG_ADV: store_load_advances_index <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) mem_rd <= mem[mem_a];

  always_comb begin
    mem_a = (state == S_EXEC && op == OP_HOSTWR) ? imm[MEM_AW-1:0] : addr16[MEM_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      frame_ok <= '0;
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      index_reg <= 16'd0;
      pc_reg <= PC_RESET;
      stack_count <= '0;
      delay_count <= 8'd0;
      sound_count <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation; rx <= reg_x; ry <= reg_y; imm <= immediate;
            rnd <= random_byte; hdat <= host_data;
            step <= 5'd0; st <= ST_OK; row_r <= 64'd0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (op)
            OP_CLEAR: state <= S_CLR;
            OP_DRAW: begin
              col <= vx[5:0];
              top <= vy[ROW_AW-1:0];
              v[15] <= 8'd0;
              if (imm[3:0] != 4'd0) state <= S_MRD;
            end
            OP_JUMP: pc_reg <= imm;
            OP_JUMPOFF: pc_reg <= imm + {3'd0, jsrc};
            OP_CALL: begin
              if (stack_count == STACK_DEPTH[STK_AW:0]) st <= ST_OVER;
              else begin
                stack[stack_count[STK_AW-1:0]] <= pc_reg;
                stack_count <= stack_count + 1'b1;
                pc_reg <= imm;
              end
            end
            OP_RET: begin
              if (stack_count == '0) st <= ST_UNDER;
              else begin
                stack_count <= stack_count - 1'b1;
                pc_reg <= stack[stack_count[STK_AW-1:0] - 1'b1];
              end
            end
            OP_SEQ_N: if (vx == imm[7:0]) pc_reg <= pc_reg + 12'd2;
            OP_SNE_N: if (vx != imm[7:0]) pc_reg <= pc_reg + 12'd2;
            OP_SEQ_R: if (vx == vy) pc_reg <= pc_reg + 12'd2;
            OP_SNE_R: if (vx != vy) pc_reg <= pc_reg + 12'd2;
            OP_LD_N: v[rx] <= imm[7:0];
            OP_ADD_N: v[rx] <= vx + imm[7:0];
            OP_MOV: v[rx] <= vy;
            OP_OR: v[rx] <= vx | vy;
            OP_AND: v[rx] <= vx & vy;
            OP_XOR: v[rx] <= vx ^ vy;
            OP_SHR: begin
              v[rx] <= {1'b0, sh_src[7:1]};
              v[15] <= {7'd0, sh_src[0]};
            end
            OP_SHL: begin
              v[rx] <= {sh_src[6:0], 1'b0};
              v[15] <= {7'd0, sh_src[7]};
            end
            OP_ADC: begin
              v[rx] <= sum9[7:0];
              v[15] <= {7'd0, sum9[8]};
            end
            OP_SUB: begin
              v[rx] <= vx - vy;
              v[15] <= {7'd0, vx >= vy};
            end
            OP_SUBN: begin
              v[rx] <= vy - vx;
              v[15] <= {7'd0, vy >= vx};
            end
            OP_LDI: index_reg <= {4'd0, imm};
            OP_ADDI: index_reg <= index_reg + {8'd0, vx};
            OP_FONT: index_reg <= {4'd0, FONT_BASE} + {6'd0, vx, 2'd0} + {8'd0, vx};
            OP_STORE: state <= S_MWR;
            OP_LOAD: state <= S_MRD;
            OP_RAND: v[rx] <= rnd & imm[7:0];
            OP_SET_DT: delay_count <= vx;
            OP_GET_DT: v[rx] <= delay_count;
            OP_SET_ST: sound_count <= vx;
            OP_BCD: begin
              bcd_val <= vx; bcd_h <= 8'd0; bcd_t <= 8'd0;
              state <= S_BCD;
            end
            OP_HOSTWR: mem[mem_a] <= hdat;
            OP_ROWRD: row_r <= frame_ok[rd_sel] ? frame[rd_sel] : 64'd0;
            default: ;
          endcase
        end
        S_MRD: state <= S_MUSE;
        S_MUSE: begin
          if (op == OP_DRAW) begin
            if ((cur_row & bits) != 64'd0) v[15] <= 8'd1;
            frame[drow[ROW_AW-1:0]] <= cur_row ^ bits;
            frame_ok[drow[ROW_AW-1:0]] <= 1'b1;
            if (step[3:0] + 4'd1 == imm[3:0] || drow == 6'(SCREEN_ROWS - 1)) state <= S_DONE;
            else begin step <= step + 5'd1; state <= S_MRD; end
          end else begin
            v[step[3:0]] <= mem_rd;
            if (step[3:0] == rx) begin
              if (store_load_advances_index) index_reg <= index_reg + {12'd0, rx} + 16'd1;
              state <= S_DONE;
            end else begin step <= step + 5'd1; state <= S_MRD; end
          end
        end
        S_MWR: begin
          mem[mem_a] <= v[step[3:0]];
          if (step[3:0] == rx) begin
            if (store_load_advances_index) index_reg <= index_reg + {12'd0, rx} + 16'd1;
            state <= S_DONE;
          end else step <= step + 5'd1;
        end
        S_CLR: begin
          frame_ok <= '0;
          step <= step + 5'd1;
          if (step == 5'(SCREEN_ROWS - 1)) state <= S_DONE;
        end
        S_BCD: begin
          if (bcd_val >= 8'd100) begin
            bcd_val <= bcd_val - 8'd100; bcd_h <= bcd_h + 8'd1;
          end else if (bcd_val >= 8'd10) begin
            bcd_val <= bcd_val - 8'd10; bcd_t <= bcd_t + 8'd1;
          end else begin
            unique case (step[1:0])
              2'd0: mem[mem_a] <= bcd_h;
              2'd1: mem[mem_a] <= bcd_t;
              default: mem[mem_a] <= bcd_val;
            endcase
            step <= step + 5'd1;
            if (step[1:0] == 2'd2) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            res.status <= st; res.next_pc <= pc_reg; res.index_value <= index_reg;
            res.flag_value <= v[15]; res.display_row <= row_r;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = res.status;
  assign next_pc = res.next_pc;
  assign index_value = res.index_value;
  assign flag_value = res.flag_value;
  assign display_row = res.display_row;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= STACK_DEPTH[STK_AW:0]) else $error("stack count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire
